### sv/timestamp_reorder_buffer_macros.svh
// Assertion macros for the timestamp reorder buffer checker.
// Needs signals aclk and aresetn in the scope where a macro is used.
`ifndef TIMESTAMP_REORDER_BUFFER_MACROS_SVH
`define TIMESTAMP_REORDER_BUFFER_MACROS_SVH

// antecedent and consequent in the same cycle
`define TRO_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tro same-cycle check failed");

// consequent in the cycle after the antecedent
`define TRO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tro next-cycle check failed");

`endif

### sv/tro_pkg.sv
// Shared types and constants of the timestamp reorder buffer.
// No dependencies.
package tro_pkg;

    localparam int STAMP_W  = 48;
    localparam int HANDLE_W = 16;
    localparam int ACTION_W = 4;
    localparam int SIZE_W   = 24;
    localparam int BYTES_W  = 32;
    localparam int WINMS_W  = 16;
    localparam int WIN_W    = 26;
    localparam int RES_W    = 6;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 96;

    localparam logic [RES_W-1:0] MAX_RESULTS = RES_W'(32);
    localparam logic [WIN_W-1:0] US_PER_MS   = WIN_W'(1000);
    localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 32'd1048576;
    localparam logic [WINMS_W-1:0] WINDOW_RESET    = 16'd100;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam logic [0:0] REG_MAX_BYTES = 1'd0;
    localparam logic [0:0] REG_WINDOW    = 1'd1;

    typedef struct packed {
        logic [STAMP_W-1:0]  stamp;
        logic [STAMP_W-1:0]  arrival;
        logic [HANDLE_W-1:0] handle;
        logic [ACTION_W-1:0] action;
        logic [SIZE_W-1:0]   size;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_INS_RD    = 6'b000010,
        ST_INS_CMP   = 6'b000100,
        ST_FRONT_RD  = 6'b001000,
        ST_FRONT_CHK = 6'b010000,
        ST_FINISH    = 6'b100000
    } state_t;

endpackage

### sv/tro_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tro_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/timestamp_reorder_buffer.sv
// Top level of the timestamp reorder buffer: sorted queue in a circular RAM.
// Depends on tro_pkg and tro_ram.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  input    | s_tvalid / s_tready      | s_tuser op, s_tdata entry fields
//  result   | m_tvalid / m_tready      | m_tdata released entry, m_tlast
//  config   | cfg_we                   | cfg_addr index, cfg_wdata value
//
// An item is accepted in idle. A push runs a shift loop over the RAM read port
// (read, compare) per held entry with a later stamp, then writes the new entry
// in the read state (new front) or the compare state; every release check
// reads the front, then decides, the last one stopping at the front read when
// the queue is empty or the release cap is hit. An item ends in ST_FINISH.
// No clearing pass after reset; entries are read only below the count.
// A stalled result stops the release loop until the output register frees up.
module timestamp_reorder_buffer
    import tro_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_us, stamp, payload_handle, action_kind, payload_bytes, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // op
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_stamp, out_handle, out_action, out_bytes, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_addr,
    input  logic [BYTES_W-1:0]    cfg_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t               state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    entry_t               new_reg, new_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [BYTES_W-1:0]   bytes_reg, bytes_next;
    logic [STAMP_W-1:0]   back_reg, back_next;
    logic [RES_W-1:0]     n_reg, n_next;
    entry_t               hold_reg, hold_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;
    logic [BYTES_W-1:0]   max_reg;
    logic [WINMS_W-1:0]   win_ms_reg;
    logic [WIN_W-1:0]     window_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    entry_t               ram_wdata, front;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic                 out_free;
    logic                 release_hit;
    logic [STAMP_W-1:0]   span, waited;
    logic [BYTES_W:0]     bytes_sum;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] lpos);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(lpos);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [OUT_DATA_W-1:0] pack_out(input entry_t e);
        return {4'd0, e.size, e.action, e.handle, e.stamp};
    endfunction

    tro_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign front    = entry_t'(ram_rdata);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    assign span      = back_reg - front.stamp;
    assign waited    = new_reg.arrival - front.arrival;
    assign bytes_sum = (BYTES_W+1)'(bytes_reg) + (BYTES_W+1)'(new_reg.size);

    always_comb begin
        release_hit = (op_reg == OP_FLUSH) || (bytes_reg >= max_reg)
                   || (count_reg >= CW'(DEPTH))
                   || (span >= STAMP_W'(window_reg))
                   || ((new_reg.arrival >= front.arrival)
                       && (waited >= STAMP_W'(window_reg)));
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        new_next        = new_reg;
        pos_next        = pos_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        bytes_next      = bytes_reg;
        back_next       = back_reg;
        n_next          = n_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = phys(head_reg, pos_reg);
        ram_wdata       = new_reg;
        ram_raddr       = head_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next          = s_tuser;
                    new_next.arrival = s_tdata[47:0];
                    new_next.stamp   = s_tdata[95:48];
                    new_next.handle  = s_tdata[111:96];
                    new_next.action  = s_tdata[115:112];
                    new_next.size    = s_tdata[139:116];
                    n_next           = '0;
                    pos_next         = count_reg;
                    if (s_tuser == OP_PUSH && count_reg < CW'(DEPTH)) begin
                        state_next = ST_INS_RD;
                    end else begin
                        state_next = ST_FRONT_RD;
                    end
                end
            end
            ST_INS_RD: begin
                ram_raddr = phys(head_reg, pos_reg - CW'(1));
                if (pos_reg == '0) begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    bytes_next = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
                    if (count_reg == '0) begin
                        back_next = new_reg.stamp;
                    end
                    state_next = ST_FRONT_RD;
                end else begin
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                ram_we = 1'b1;
                if (front.stamp > new_reg.stamp) begin
                    ram_wdata  = front;
                    pos_next   = pos_reg - CW'(1);
                    state_next = ST_INS_RD;
                end else begin
                    count_next = count_reg + CW'(1);
                    bytes_next = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
                    if (pos_reg == count_reg) begin
                        back_next = new_reg.stamp;
                    end
                    state_next = ST_FRONT_RD;
                end
            end
            ST_FRONT_RD: begin
                if (count_reg == '0 || n_reg == MAX_RESULTS) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_FRONT_CHK;
                end
            end
            ST_FRONT_CHK: begin
                if (!release_hit) begin
                    state_next = ST_FINISH;
                end else if (!hold_valid_reg || out_free) begin
                    if (hold_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_data_next  = pack_out(hold_reg);
                        m_last_next  = 1'b0;
                    end
                    hold_next       = front;
                    hold_valid_next = 1'b1;
                    head_next       = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                    count_next      = count_reg - CW'(1);
                    bytes_next      = (bytes_reg >= BYTES_W'(front.size))
                                    ? bytes_reg - BYTES_W'(front.size) : '0;
                    n_next          = n_reg + RES_W'(1);
                    state_next      = ST_FRONT_RD;
                end
            end
            ST_FINISH: begin
                if (!hold_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_data_next     = pack_out(hold_reg);
                    m_last_next     = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            bytes_reg      <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            max_reg        <= MAX_BYTES_RESET;
            win_ms_reg     <= WINDOW_RESET;
            window_reg     <= WIN_W'(WINDOW_RESET) * US_PER_MS;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            bytes_reg      <= bytes_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
            window_reg     <= WIN_W'(win_ms_reg) * US_PER_MS;
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_MAX_BYTES: max_reg    <= cfg_wdata;
                    REG_WINDOW:    win_ms_reg <= cfg_wdata[WINMS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        new_reg    <= new_next;
        pos_reg    <= pos_next;
        back_reg   <= back_next;
        n_reg      <= n_next;
        hold_reg   <= hold_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

endmodule

### sv/tro_checker.sv
// Port-level checks for the timestamp reorder buffer, bound to the top level.
// Depends on tro_pkg and timestamp_reorder_buffer_macros.svh.
`include "timestamp_reorder_buffer_macros.svh"

module tro_checker
    import tro_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [1:0]            s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast,
    input logic                  cfg_we,
    input logic [0:0]            cfg_addr,
    input logic [BYTES_W-1:0]    cfg_wdata
);

    // a stalled result holds
    `TRO_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // one item at a time
    `TRO_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

    // padding stays zero
    `TRO_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[95:92] == 4'd0)

endmodule

bind timestamp_reorder_buffer tro_checker u_tro_checker (.*);

### verif/tb.sv
// Testbench of timestamp_reorder_buffer: pushes, ticks and flushes against a
// timestamp-sorted queue predictor, checking every released entry in order.
// Depends on tro_pkg and the timestamp_reorder_buffer RTL.
module tb;
    import tro_pkg::*;

    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int QDEPTH    = 32;
    localparam int MAX_REL   = 32;
    localparam int SETTLE    = 300;
    localparam int WDOG_MAX  = 20000;

    typedef struct {
        logic [STAMP_W-1:0]  stamp;
        logic [STAMP_W-1:0]  arrival;
        logic [HANDLE_W-1:0] handle;
        logic [ACTION_W-1:0] action;
        logic [SIZE_W-1:0]   size;
    } slot_t;

    typedef struct {
        logic [STAMP_W-1:0]  stamp;
        logic [HANDLE_W-1:0] handle;
        logic [ACTION_W-1:0] action;
        logic [SIZE_W-1:0]   size;
        logic                last;
    } release_t;

    logic aclk, aresetn;
    logic s_tvalid, s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic [1:0] s_tuser;
    logic m_tvalid, m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_we;
    logic [0:0] cfg_addr;
    logic [BYTES_W-1:0] cfg_wdata;

    timestamp_reorder_buffer dut (.*);

    // predictor state
    slot_t held [QDEPTH];
    int unsigned held_cnt;
    logic [BYTES_W-1:0] held_bytes;
    logic [BYTES_W-1:0] byte_limit;
    logic [WINMS_W-1:0] win_ms;
    release_t pending_releases[$];

    int errors, items_sent, releases_seen, cfg_writes, idle_cycles;
    int s_idle_pct, r_idle_pct;
    logic [STAMP_W-1:0] clock_us;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit release_due(logic [STAMP_W-1:0] now);
        logic [63:0] win_us;
        win_us = 64'(win_ms) * 64'd1000;
        if (held_cnt == 0) return 0;
        if (held_bytes >= byte_limit || held_cnt >= QDEPTH) return 1;
        if (64'(held[held_cnt-1].stamp - held[0].stamp) >= win_us) return 1;
        return now >= held[0].arrival && 64'(now - held[0].arrival) >= win_us;
    endfunction

    function automatic void predict_releases(logic [1:0] op, logic [STAMP_W-1:0] now,
            logic [STAMP_W-1:0] stamp, logic [HANDLE_W-1:0] handle,
            logic [ACTION_W-1:0] action, logic [SIZE_W-1:0] size);
        int unsigned pos;
        int n;
        logic [32:0] sum;
        release_t r;
        if (op == OP_PUSH && held_cnt < QDEPTH) begin
            pos = 0;
            while (pos < held_cnt && held[pos].stamp <= stamp) pos++;
            for (int i = held_cnt; i > pos; i--) held[i] = held[i-1];
            held[pos] = '{stamp, now, handle, action, size};
            held_cnt++;
            sum = {1'b0, held_bytes} + 33'(size);
            held_bytes = sum[32] ? '1 : sum[31:0];
        end
        n = 0;
        while (n < MAX_REL && held_cnt > 0 && (op == OP_FLUSH || release_due(now))) begin
            r = '{held[0].stamp, held[0].handle, held[0].action, held[0].size, 1'b0};
            pending_releases.push_back(r);
            held_bytes = (held_bytes >= BYTES_W'(held[0].size)) ?
                         held_bytes - BYTES_W'(held[0].size) : '0;
            for (int i = 1; i < held_cnt; i++) held[i-1] = held[i];
            held_cnt--;
            n++;
        end
        if (n > 0) pending_releases[$].last = 1'b1;
    endfunction

    // result checker and receiver stalls
    always @(posedge aclk) begin
        release_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                releases_seen++;
                if (pending_releases.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected release, actual %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    e = pending_releases[0];
                    pending_releases.delete(0);
                    if (m_tdata[47:0] !== e.stamp || m_tdata[63:48] !== e.handle ||
                        m_tdata[67:64] !== e.action || m_tdata[91:68] !== e.size ||
                        m_tdata[95:92] !== 4'h0 || m_tlast !== e.last) begin
                        errors++;
                        $display("%0t: mismatch expected stamp %h handle %h action %h size %h last %b",
                                 $time, e.stamp, e.handle, e.action, e.size, e.last);
                        $display("%0t:          actual stamp %h handle %h action %h size %h last %b",
                                 $time, m_tdata[47:0], m_tdata[63:48], m_tdata[67:64],
                                 m_tdata[91:68], m_tlast);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= r_idle_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [STAMP_W-1:0] now,
            logic [STAMP_W-1:0] stamp, logic [HANDLE_W-1:0] handle,
            logic [ACTION_W-1:0] action, logic [SIZE_W-1:0] size);
        if ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'h0, size, action, handle, stamp, now};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_releases(op, now, stamp, handle, action, size);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_releases.size() != 0 || !s_tready) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [BYTES_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == REG_MAX_BYTES) byte_limit = val;
        else win_ms = val[WINMS_W-1:0];
        cfg_writes++;
    endtask

    task automatic configure(logic [BYTES_W-1:0] limit, logic [WINMS_W-1:0] ms);
        wait_idle();
        write_reg(REG_MAX_BYTES, limit);
        write_reg(REG_WINDOW, 32'(ms));
    endtask

    task automatic test_field_extremes();
        send_item(OP_PUSH, '1, '1, '1, '1, '1);
        send_item(OP_PUSH, '0, '0, '0, '0, '0);
        send_item(OP_FLUSH, '0, '1, '1, '1, '1);
        send_item(OP_FLUSH, 48'h5a5a_a5a5_5a5a, '0, '0, '0, '0);
        send_item(OP_PUSH, 48'h1000, 48'h1000, 16'h1234, 4'h5, 24'h10);
        send_item(OP_SPARE, 48'h1000, '1, '1, '1, '1);
        send_item(OP_FLUSH, 48'h1000, '0, '0, '0, '0);
    endtask

    task automatic test_equal_stamps();
        send_item(OP_PUSH, 48'd2000, 48'd500, 16'h0001, 4'h1, 24'd1);
        send_item(OP_PUSH, 48'd2001, 48'd400, 16'h0002, 4'h2, 24'd1);
        send_item(OP_PUSH, 48'd2002, 48'd500, 16'h0003, 4'h3, 24'd1);
        send_item(OP_PUSH, 48'd2003, 48'd500, 16'h0004, 4'h4, 24'd1);
        send_item(OP_FLUSH, 48'd2004, '0, '0, '0, '0);
    endtask

    task automatic test_window_and_time();
        // window 100 ms: span release, wait release, time going backwards
        send_item(OP_PUSH, 48'd500000, 48'd500000, 16'h0010, 4'h6, 24'd100);
        send_item(OP_PUSH, 48'd500010, 48'd600000, 16'h0011, 4'h7, 24'd100);
        send_item(OP_PUSH, 48'd500020, 48'd550000, 16'h0012, 4'h8, 24'd100);
        send_item(OP_TICK, 48'd100, '0, '0, '0, '0);
        send_item(OP_TICK, 48'd650020, '0, '0, '0, '0);
        send_item(OP_FLUSH, 48'd650030, '0, '0, '0, '0);
    endtask

    task automatic test_byte_limit();
        send_item(OP_PUSH, 48'd10, 48'd10, 16'h0020, 4'h9, 24'hff_ffff);
        send_item(OP_PUSH, 48'd11, 48'd9, 16'h0021, 4'ha, 24'h00_0001);
        send_item(OP_FLUSH, 48'd12, '0, '0, '0, '0);
    endtask

    task automatic run_random(int count);
        logic [1:0] op;
        logic [STAMP_W-1:0] stamp, last_stamp;
        logic [63:0] win_us, jit;
        int pick;
        win_us = 64'(win_ms) * 64'd1000;
        last_stamp = clock_us;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            clock_us = clock_us + 48'($urandom_range(0, 32'(win_us / 3) + 20));
            if ($urandom_range(0, 19) == 0) clock_us = clock_us - 48'($urandom_range(0, 50));
            jit = 64'($urandom_range(0, 32'(win_us / 2) + 5));
            stamp = (64'(clock_us) > jit) ? clock_us - 48'(jit) : '0;
            if ($urandom_range(0, 4) == 0) stamp = last_stamp;
            last_stamp = stamp;
            if (pick < 68) op = OP_PUSH;
            else if (pick < 84) op = OP_TICK;
            else if (pick < 89) op = OP_FLUSH;
            else if (pick < 93) op = OP_SPARE;
            else op = OP_PUSH;
            if (pick >= 93)
                send_item(op, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                          $urandom, $urandom);
            else
                send_item(op, clock_us, stamp, $urandom, $urandom,
                          24'($urandom_range(0, (byte_limit > 32'h3f_ffff) ?
                                                32'hff_ffff : byte_limit / 4 + 1)));
        end
        send_item(OP_FLUSH, clock_us, '0, '0, '0, '0);
    endtask

    task automatic test_random_settings();
        configure(32'h0000_0001, 16'd0);
        run_random(12);
        configure(32'hffff_ffff, 16'd65535);
        run_random(20);
        configure(32'd5000, 16'd3);
        run_random(25);
        configure(32'd1048576, 16'd1);
        run_random(25);
        configure(32'd60_000_000, 16'd20);
        run_random(25);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        cfg_we   <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        held_cnt = 0;
        held_bytes = '0;
        byte_limit = MAX_BYTES_RESET;
        win_ms = WINDOW_RESET;
        errors = 0; items_sent = 0; releases_seen = 0; cfg_writes = 0; idle_cycles = 0;
        s_idle_pct = 35; r_idle_pct = 74;
        clock_us = 48'd1_000_000;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_equal_stamps();
        test_window_and_time();
        configure(32'd1000, 16'd100);
        test_byte_limit();
        test_random_settings();
        s_idle_pct = 74; r_idle_pct = 35;
        test_random_settings();
        s_idle_pct = 0; r_idle_pct = 0;
        configure(MAX_BYTES_RESET, WINDOW_RESET);
        run_random(10);
        wait_idle();

        $display("tb: %0d items sent, %0d entries released, %0d register writes",
                 items_sent, releases_seen, cfg_writes);
        $display("tb: pushes, ticks, flushes, ties and byte and window limits over several settings");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### files.f
+incdir+sv
sv/tro_pkg.sv
sv/tro_ram.sv
sv/timestamp_reorder_buffer.sv
sv/tro_checker.sv
verif/tb.sv
